>>> hdl/lruc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruc_pkg - shared definitions for the LRU associative cache
// Store geometry, item kinds, sequencer states and the per-cell control bundle.
// ----------------------------------------------------------------------------
package lruc_pkg;

    localparam int DEPTH   = 16;
    localparam int KEY_W   = 32;
    localparam int PAY_W   = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_PEEK   = 2'd1,
        KIND_TOUCH  = 2'd2,
        KIND_INSERT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    // per-cell control from the sequencer
    typedef struct packed {
        logic cmp_en;   // latch key compare
        logic shift;    // take neighbor's entry
    } t_cell_ctl;

endpackage

>>> hdl/lruc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruc_cell - one recency position of the cache
// Holds a key and payload, registers its key compare, and shifts in the entry
// of the next more recent position on request.
// ----------------------------------------------------------------------------
module lruc_cell
    import lruc_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [KEY_W-1:0] i_cmp_key,
    input  logic [KEY_W-1:0] i_prev_key,
    input  logic [PAY_W-1:0] i_prev_pay,
    output logic [KEY_W-1:0] o_key,
    output logic [PAY_W-1:0] o_pay,
    output logic             o_match
);

    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_pay;
    logic             r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key <= i_prev_key;
            r_pay <= i_prev_pay;
        end
        if (i_ctl.cmp_en) begin
            r_match <= (r_key == i_cmp_key);
        end
    end

    assign o_key   = r_key;
    assign o_pay   = r_pay;
    assign o_match = r_match;

endmodule

>>> hdl/lru_associative_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_associative_cache - fully associative cache with LRU replacement
// Chain of entry cells kept in recency order with a two-step sequencer.
// ----------------------------------------------------------------------------
// The store is a row of DEPTH cells, cell 0 the most recent entry. Each word
// takes two steps: in the first every cell compares its key with the word's key
// and registers the result; in the second the first live match is picked, the
// result word is loaded into the output register and the cells from the front
// down to the chosen position shift by one, the front cell taking the moved or
// inserted entry. A new word is taken in the same cycle the previous one
// finishes. A pending result waiting on o_out_valid/i_out_stall holds the
// second step; the block takes the next word as soon as the output register
// frees. Capacity (i_cfg_we/i_cfg_wdata) must be written only while idle; the
// user is bound, the block does not enforce this. 0 or any value above DEPTH
// uses the whole store. Cells beyond the fill count are never reported.
// ----------------------------------------------------------------------------
module lru_associative_cache
    import lruc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // config
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    // input channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_kind,
    input  logic [KEY_W-1:0] i_key,
    input  logic [PAY_W-1:0] i_payload,
    // output channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_hit,
    output logic [PAY_W-1:0] o_found_payload,
    output logic             o_victim_valid,
    output logic [KEY_W-1:0] o_victim_key,
    output logic [PAY_W-1:0] o_victim_payload,
    output logic [31:0]      o_hits_total,
    output logic [31:0]      o_misses_total,
    output logic [CNT_W-1:0] o_fill
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] r_count;
    logic [31:0]      r_hits, r_misses;
    t_kind            r_kind;
    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_pay;
    logic             r_out_valid;

    // result word register
    logic             r_hit;
    logic [PAY_W-1:0] r_found_pay;
    logic             r_victim_valid;
    logic [KEY_W-1:0] r_victim_key;
    logic [PAY_W-1:0] r_victim_pay;

    // cell row
    t_cell_ctl        cell_ctl  [DEPTH];
    logic [KEY_W-1:0] cell_key  [DEPTH];
    logic [PAY_W-1:0] cell_pay  [DEPTH];
    logic [DEPTH-1:0] cell_match;
    logic [KEY_W-1:0] front_key;
    logic [PAY_W-1:0] front_pay;

    // update step
    logic             upd_go;
    logic             in_acc;
    logic [DEPTH-1:0] live, mlive, first, move_mask;
    logic             found;
    logic [PAY_W-1:0] found_pay;
    logic [KEY_W-1:0] tail_key;
    logic [PAY_W-1:0] tail_pay;
    logic [CNT_W-1:0] cap_eff;
    logic             is_ins, evict, do_move;
    logic [CNT_W-1:0] ins_pos;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_front
                lruc_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctl      (cell_ctl[g]),
                    .i_cmp_key  (r_key),
                    .i_prev_key (front_key),
                    .i_prev_pay (front_pay),
                    .o_key      (cell_key[g]),
                    .o_pay      (cell_pay[g]),
                    .o_match    (cell_match[g])
                );
            end else begin : g_rest
                lruc_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctl      (cell_ctl[g]),
                    .i_cmp_key  (r_key),
                    .i_prev_key (cell_key[g-1]),
                    .i_prev_pay (cell_pay[g-1]),
                    .o_key      (cell_key[g]),
                    .o_pay      (cell_pay[g]),
                    .o_match    (cell_match[g])
                );
            end
        end
    endgenerate

    // --- match selection, victim read, shift masks
    always_comb begin
        is_ins  = (r_kind == KIND_INSERT);
        cap_eff = (r_cap == '0 || r_cap > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : r_cap;
        evict   = is_ins && (r_count >= cap_eff) && (r_count != '0);
        ins_pos = evict ? (r_count - CNT_W'(1)) : r_count;

        for (int i = 0; i < DEPTH; i++) begin
            live[i] = (CNT_W'(i) < r_count);
        end
        mlive = cell_match & live;
        first = mlive & (~mlive + DEPTH'(1));   // lowest live match
        move_mask = first | (first - DEPTH'(1));
        found = !is_ins && (mlive != '0);
        do_move = found && (r_kind == KIND_LOOKUP || r_kind == KIND_TOUCH);

        found_pay = '0;
        tail_key  = '0;
        tail_pay  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            found_pay = found_pay | ({PAY_W{first[i]}} & cell_pay[i]);
            if (CNT_W'(i + 1) == r_count) begin
                tail_key = cell_key[i];
                tail_pay = cell_pay[i];
            end
        end

        front_key = r_key;   // a moved entry carries the searched key
        front_pay = is_ins ? r_pay : found_pay;

        for (int i = 0; i < DEPTH; i++) begin
            cell_ctl[i].cmp_en = (r_state == S_CMP);
            cell_ctl[i].shift  = upd_go &&
                (is_ins ? (CNT_W'(i) <= ins_pos) : (do_move && move_mask[i]));
        end
    end

    // --- sequencer
    assign upd_go     = (r_state == S_UPD) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !((r_state == S_IDLE) || upd_go);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  n_state = in_acc ? S_CMP : S_IDLE;
            S_CMP:   n_state = S_UPD;
            S_UPD:   begin
                if (upd_go) begin
                    n_state = in_acc ? S_CMP : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // --- item capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= t_kind'(i_kind);
            r_key  <= i_key;
            r_pay  <= i_payload;
        end
    end

    // --- control state: capacity, fill, counters, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= '0;
            r_count     <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (upd_go) begin
                r_out_valid <= 1'b1;
                if (is_ins) begin
                    r_count <= ins_pos + CNT_W'(1);
                end
                if (r_kind == KIND_LOOKUP) begin
                    if (found) begin
                        r_hits <= r_hits + 32'd1;
                    end else begin
                        r_misses <= r_misses + 32'd1;
                    end
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // --- result word
    always_ff @(posedge i_clk) begin
        if (upd_go) begin
            r_hit          <= found;
            r_found_pay    <= found ? found_pay : '0;
            r_victim_valid <= evict;
            r_victim_key   <= evict ? tail_key : '0;
            r_victim_pay   <= evict ? tail_pay : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_hit            = r_hit;
    assign o_found_payload  = r_found_pay;
    assign o_victim_valid   = r_victim_valid;
    assign o_victim_key     = r_victim_key;
    assign o_victim_payload = r_victim_pay;
    assign o_hits_total     = r_hits;
    assign o_misses_total   = r_misses;
    assign o_fill           = r_count;

    // --- checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill above store depth");

    a_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !upd_go |=> $stable(r_count))
        else $error("fill changed outside update step");

    a_cmp_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> o_in_stall)
        else $error("input taken during compare step");

    a_match_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd_go && found) |-> (r_count != '0))
        else $error("match reported in empty store");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |=> (r_state == S_UPD))
        else $error("compare step not followed by update");

endmodule
